>>> hw/rtl/rpa_pkg.sv
// Shared types, widths and constants of the relay autotuner.
// No dependencies; imported by rpa_muldiv, relay_pid_autotuner_unit and the testbench.
package rpa_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int TIME_W    = 32;
  localparam int GAIN_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int SUM_W     = 40;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRV_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRV_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RULE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLES   = 3'd5;

  localparam logic [1:0] RULE_BASIC     = 2'd0;
  localparam logic [1:0] RULE_LESS_OVER = 2'd1;
  localparam logic [1:0] RULE_NO_OVER   = 2'd2;

  // serial multiply-divide unit widths
  localparam int MD_A_W   = 41;
  localparam int MD_B_W   = 33;
  localparam int MD_P_W   = MD_A_W + MD_B_W;
  localparam int MD_D_W   = 34;
  localparam int MD_CNT_W = 6;
  localparam int KP_SHIFT = 30 - FRAC_BITS;

  localparam logic [30:0] FOUR_OVER_PI_Q30 = 31'd1367130551;
  localparam logic [9:0]  THOUSAND         = 10'd1000;

  typedef struct packed {
    logic              start;
    logic [MD_A_W-1:0] a;
    logic [MD_B_W-1:0] b;
    logic              shr;
    logic [MD_D_W-1:0] den;
  } rpa_md_req_t;

  typedef struct packed {
    logic              done;
    logic [GAIN_W-1:0] quot;
  } rpa_md_rsp_t;

  function automatic logic [9:0] rule_kp_milli(input logic [1:0] rule);
    logic [9:0] v;
    case (rule)
      RULE_LESS_OVER: v = 10'd330;
      RULE_NO_OVER:   v = 10'd200;
      default:        v = 10'd600;
    endcase
    return v;
  endfunction

  function automatic logic [8:0] rule_td_milli(input logic [1:0] rule);
    logic [8:0] v;
    case (rule)
      RULE_LESS_OVER: v = 9'd330;
      RULE_NO_OVER:   v = 9'd330;
      default:        v = 9'd125;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/rpa_muldiv.sv
// Serial multiply-divide unit: q = min(floor(a*b[>>shift]/den), 2^32-1).
// One multiplier bit, then one quotient bit per cycle. Depends on rpa_pkg.
module rpa_muldiv import rpa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rpa_md_req_t req_i,
  output rpa_md_rsp_t rsp_o
);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_MUL  = 2'd1;
  localparam logic [1:0] M_NORM = 2'd2;
  localparam logic [1:0] M_DIV  = 2'd3;

  logic [1:0]          st_q, st_d;
  logic [MD_CNT_W-1:0] cnt_q, cnt_d;
  logic                done_q, done_d;
  logic [MD_A_W-1:0]   a_q, a_d;
  logic [MD_B_W-1:0]   b_q, b_d;
  logic [MD_P_W-1:0]   acc_q, acc_d;
  logic [MD_D_W-1:0]   den_q, den_d;
  logic                shr_q, shr_d;
  logic [MD_D_W-1:0]   rem_q, rem_d;
  logic [GAIN_W-1:0]   low_q, low_d;

  logic [MD_P_W-1:0]        acc_step, norm;
  logic [MD_P_W-GAIN_W-1:0] hi;
  logic                     sat;
  logic [MD_D_W:0]          trial;
  logic [MD_D_W+1:0]        diff;
  logic                     ge;

  always_comb begin
    acc_step = {acc_q[MD_P_W-2:0], 1'b0}
             + (b_q[MD_B_W-1] ? {{(MD_P_W-MD_A_W){1'b0}}, a_q} : '0);
    norm  = shr_q ? (acc_q >> KP_SHIFT) : acc_q;
    hi    = norm[MD_P_W-1:GAIN_W];
    sat   = hi >= {{(MD_P_W-GAIN_W-MD_D_W){1'b0}}, den_q};
    trial = {rem_q, low_q[GAIN_W-1]};
    diff  = {1'b0, trial} - {2'b00, den_q};
    ge    = ~diff[MD_D_W+1];
  end

  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    den_d  = den_q;
    shr_d  = shr_q;
    rem_d  = rem_q;
    low_d  = low_q;
    unique case (st_q)
      M_IDLE: begin
        if (req_i.start) begin
          a_d   = req_i.a;
          b_d   = req_i.b;
          den_d = req_i.den;
          shr_d = req_i.shr;
          acc_d = '0;
          cnt_d = '0;
          st_d  = M_MUL;
        end
      end
      M_MUL: begin
        acc_d = acc_step;
        b_d   = {b_q[MD_B_W-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == MD_CNT_W'(MD_B_W - 1)) st_d = M_NORM;
      end
      M_NORM: begin
        cnt_d = '0;
        if (sat) begin
          low_d  = '1;
          done_d = 1'b1;
          st_d   = M_IDLE;
        end else begin
          rem_d = norm[GAIN_W+MD_D_W-1:GAIN_W];
          low_d = norm[GAIN_W-1:0];
          st_d  = M_DIV;
        end
      end
      M_DIV: begin
        rem_d = ge ? diff[MD_D_W-1:0] : trial[MD_D_W-1:0];
        low_d = {low_q[GAIN_W-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == MD_CNT_W'(GAIN_W - 1)) begin
          done_d = 1'b1;
          st_d   = M_IDLE;
        end
      end
      default: st_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= M_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
    den_q <= den_d;
    shr_q <= shr_d;
    rem_q <= rem_d;
    low_q <= low_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = low_q;

endmodule

>>> hw/rtl/relay_pid_autotuner_unit.sv
// Relay-feedback PID autotuner, top level: relay control, timing, peaks, sequencer.
// Depends on rpa_pkg and rpa_muldiv.
//
// channel | direction | handshake           | payload
// --------+-----------+---------------------+------------------------------------------
// in      | sink      | in_valid_i/in_stall_o | mode_i, sample_i, time_us_i
// out     | source    | out_valid_o/out_stall_i | drive_o, *_gain_o, finished_o
// cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A start item or an inactive sample goes to S_OUT; an active sample passes S_CHK first.
// A rise runs kp, ki, kd through the shared serial multiply-divide unit, each
// 33 multiplier bits then, unless the quotient saturates, 32 quotient bits; the end of a run adds three
// averages through the same unit. That unit sets the rate.
// Input is stalled while an item is in work; a result waits in the output
// register and the next item is taken meanwhile. cfg_ready_o is always high.
// Reset is asynchronous, active low, and loads the register defaults.
module relay_pid_autotuner_unit import rpa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  mode_i,
  input  logic [SAMPLE_W-1:0]   sample_i,
  input  logic [TIME_W-1:0]     time_us_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [15:0]           drive_o,
  output logic [GAIN_W-1:0]     prop_gain_o,
  output logic [GAIN_W-1:0]     integ_gain_o,
  output logic [GAIN_W-1:0]     deriv_gain_o,
  output logic                  finished_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DAT_W-1:0]  cfg_data_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_KP   = 3'd1;
  localparam logic [2:0] S_KI   = 3'd2;
  localparam logic [2:0] S_KD   = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_AVG  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  // configuration registers
  logic [15:0] target_q, dlow_q, dhigh_q;
  logic [1:0]  rule_q;
  logic [23:0] lint_q;
  logic [7:0]  tcyc_q;

  // tuner state; the low phase length only feeds the period on a rise
  logic [2:0]          st_q, st_d;
  logic                active_q, active_d;
  logic                relay_q, relay_d;
  logic [7:0]          cc_q, cc_d;
  logic [TIME_W-1:0]   fall_q, fall_d, rise_q, rise_d, high_q, high_d;
  logic [SAMPLE_W-1:0] ph_q, ph_d, pl_q, pl_d;
  logic [SUM_W-1:0]    sum_q [3];
  logic [SUM_W-1:0]    sum_d [3];
  logic [GAIN_W-1:0]   gain_q [3];
  logic [GAIN_W-1:0]   gain_d [3];
  logic [GAIN_W-1:0]   kp_q, kp_d, ki_q, ki_d;
  logic [15:0]         amp_q, amp_d;
  logic [TIME_W:0]     tu_q, tu_d;
  logic                sum_en_q, sum_en_d;
  logic [1:0]          idx_q, idx_d;
  logic                md_start_q, md_start_d;

  // result register
  logic              ov_q, ov_d;
  logic [15:0]       drv_q, drv_d;
  logic [GAIN_W-1:0] okp_q, okp_d, oki_q, oki_d, okd_q, okd_d;
  logic              fin_q, fin_d;

  rpa_md_req_t md_req;
  rpa_md_rsp_t md_rsp;

  rpa_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  // operand prep
  logic signed [SAMPLE_W-1:0] s_v, tgt_v, ph_v, pl_v, ph_n, pl_n;
  logic signed [16:0]         d_diff, amp_raw;
  logic [15:0]                d_mag, amp_new;
  logic [23:0]                l_eff;
  logic [9:0]                 cpk;
  logic [8:0]                 cdm;
  logic [25:0]                kp_num;
  logic [25:0]                amp_k;
  logic [MD_A_W-1:0]          kp_cd;
  logic [MD_D_W-1:0]          l_k;
  logic [TIME_W-1:0]          low_new;
  logic [TIME_W:0]            tu_raw;
  logic [SUM_W:0]             sum_add [3];
  logic [7:0]                 tc_eff;
  logic                       in_acc, fall_ev, rise_ev;

  always_comb begin
    s_v     = signed'(sample_i);
    tgt_v   = signed'(target_q);
    ph_v    = signed'(ph_q);
    pl_v    = signed'(pl_q);
    ph_n    = (s_v > ph_v) ? s_v : ph_v;
    pl_n    = (s_v < pl_v) ? s_v : pl_v;
    d_diff  = {dhigh_q[15], dhigh_q} - {dlow_q[15], dlow_q};
    d_mag   = d_diff[16] ? 16'd0 : d_diff[15:0];
    amp_raw = {ph_n[SAMPLE_W-1], ph_n} - {pl_n[SAMPLE_W-1], pl_n};
    // non-positive amplitude counts as one
    amp_new = (amp_raw[16] || amp_raw == 17'sd0) ? 16'd1 : amp_raw[15:0];
    l_eff   = (lint_q == 24'd0) ? 24'd1 : lint_q;
    cpk     = rule_kp_milli(rule_q);
    cdm     = rule_td_milli(rule_q);
    kp_num  = 26'(cpk) * 26'(d_mag);
    amp_k   = 26'(amp_q) * 26'(THOUSAND);
    kp_cd   = MD_A_W'(kp_q) * MD_A_W'(cdm);
    l_k     = MD_D_W'(l_eff) * MD_D_W'(THOUSAND);
    low_new = time_us_i - fall_q;
    tu_raw  = {1'b0, high_q} + {1'b0, low_new};
    tc_eff  = (tcyc_q < 8'd3) ? 8'd3 : tcyc_q;
    in_acc  = in_valid_i && (st_q == S_IDLE);
    fall_ev = relay_q && (s_v > tgt_v);
    rise_ev = !relay_q && (s_v < tgt_v);
    for (int k = 0; k < 3; k++) begin
      sum_add[k] = {1'b0, sum_q[k]} + (SUM_W + 1)'(gain_d[k]);
    end
  end

  always_comb begin
    md_req.start = md_start_q;
    md_req.a     = '0;
    md_req.b     = MD_B_W'(1);
    md_req.shr   = 1'b0;
    md_req.den   = MD_D_W'(1);
    case (st_q)
      S_KP: begin
        md_req.a   = MD_A_W'(kp_num);
        md_req.b   = MD_B_W'(FOUR_OVER_PI_Q30);
        md_req.shr = 1'b1;
        md_req.den = MD_D_W'(amp_k);
      end
      S_KI: begin
        md_req.a   = MD_A_W'(kp_q);
        md_req.b   = MD_B_W'({l_eff, 1'b0});
        md_req.den = MD_D_W'(tu_q);
      end
      S_KD: begin
        md_req.a   = kp_cd;
        md_req.b   = tu_q;
        md_req.den = l_k;
      end
      S_AVG: begin
        md_req.a   = MD_A_W'(sum_q[idx_q]);
        md_req.den = MD_D_W'(cc_q - 8'd2);
      end
      default: ;
    endcase
  end

  always_comb begin
    st_d       = st_q;
    active_d   = active_q;
    relay_d    = relay_q;
    cc_d       = cc_q;
    fall_d     = fall_q;
    rise_d     = rise_q;
    high_d     = high_q;
    ph_d       = ph_q;
    pl_d       = pl_q;
    sum_d      = sum_q;
    gain_d     = gain_q;
    kp_d       = kp_q;
    ki_d       = ki_q;
    amp_d      = amp_q;
    tu_d       = tu_q;
    sum_en_d   = sum_en_q;
    idx_d      = idx_q;
    md_start_d = 1'b0;
    ov_d       = ov_q && out_stall_i;
    drv_d      = drv_q;
    okp_d      = okp_q;
    oki_d      = oki_q;
    okd_d      = okd_q;
    fin_d      = fin_q;
    unique case (st_q)
      S_IDLE: begin
        if (in_acc) begin
          if (mode_i) begin
            // start: arm a run with the relay on
            active_d = 1'b1;
            relay_d  = 1'b1;
            cc_d     = '0;
            fall_d   = time_us_i;
            rise_d   = time_us_i;
            high_d   = '0;
            ph_d     = {1'b1, {(SAMPLE_W-1){1'b0}}};
            pl_d     = {1'b0, {(SAMPLE_W-1){1'b1}}};
            for (int k = 0; k < 3; k++) sum_d[k] = '0;
            st_d     = S_OUT;
          end else if (!active_q) begin
            st_d = S_OUT;
          end else begin
            ph_d = ph_n;
            pl_d = pl_n;
            st_d = S_CHK;
            if (fall_ev) begin
              relay_d = 1'b0;
              fall_d  = time_us_i;
              high_d  = time_us_i - rise_q;
              ph_d    = target_q;
            end else if (rise_ev) begin
              relay_d    = 1'b1;
              rise_d     = time_us_i;
              amp_d      = amp_new;
              tu_d       = (tu_raw == '0) ? (TIME_W + 1)'(1) : tu_raw;
              sum_en_d   = cc_q > 8'd1;
              pl_d       = target_q;
              md_start_d = 1'b1;
              st_d       = S_KP;
            end
          end
        end
      end
      S_KP: begin
        if (md_rsp.done) begin
          kp_d       = md_rsp.quot;
          md_start_d = 1'b1;
          st_d       = S_KI;
        end
      end
      S_KI: begin
        if (md_rsp.done) begin
          ki_d       = md_rsp.quot;
          md_start_d = 1'b1;
          st_d       = S_KD;
        end
      end
      S_KD: begin
        if (md_rsp.done) begin
          gain_d[0] = kp_q;
          gain_d[1] = ki_q;
          gain_d[2] = md_rsp.quot;
          // sums only while sum_en_q is set (cc_q > 1 at the rise), saturating
          if (sum_en_q) begin
            for (int k = 0; k < 3; k++) begin
              sum_d[k] = sum_add[k][SUM_W] ? '1 : sum_add[k][SUM_W-1:0];
            end
          end
          if (cc_q != 8'hFF) cc_d = cc_q + 8'd1;
          st_d = S_CHK;
        end
      end
      S_CHK: begin
        if (active_q && cc_q >= tc_eff) begin
          active_d   = 1'b0;
          relay_d    = 1'b0;
          idx_d      = '0;
          md_start_d = 1'b1;
          st_d       = S_AVG;
        end else begin
          st_d = S_OUT;
        end
      end
      S_AVG: begin
        if (md_rsp.done) begin
          gain_d[idx_q] = md_rsp.quot;
          if (idx_q == 2'd2) begin
            st_d = S_OUT;
          end else begin
            idx_d      = idx_q + 2'd1;
            md_start_d = 1'b1;
          end
        end
      end
      S_OUT: begin
        if (!ov_q || !out_stall_i) begin
          ov_d  = 1'b1;
          drv_d = (active_q && relay_q) ? dhigh_q : dlow_q;
          okp_d = gain_q[0];
          oki_d = gain_q[1];
          okd_d = gain_q[2];
          fin_d = !active_q && (cc_q != 8'd0);
          st_d  = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= '0;
      dlow_q     <= '0;
      dhigh_q    <= 16'd255;
      rule_q     <= RULE_BASIC;
      lint_q     <= 24'd1000;
      tcyc_q     <= 8'd10;
      st_q       <= S_IDLE;
      active_q   <= 1'b0;
      relay_q    <= 1'b0;
      cc_q       <= '0;
      fall_q     <= '0;
      rise_q     <= '0;
      high_q     <= '0;
      ph_q       <= {1'b1, {(SAMPLE_W-1){1'b0}}};
      pl_q       <= {1'b0, {(SAMPLE_W-1){1'b1}}};
      for (int k = 0; k < 3; k++) begin
        sum_q[k]  <= '0;
        gain_q[k] <= '0;
      end
      md_start_q <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_TARGET:   target_q <= cfg_data_i[15:0];
          REG_DRV_LOW:  dlow_q   <= cfg_data_i[15:0];
          REG_DRV_HIGH: dhigh_q  <= cfg_data_i[15:0];
          REG_RULE:     rule_q   <= cfg_data_i[1:0];
          REG_INTERVAL: lint_q   <= cfg_data_i[23:0];
          REG_CYCLES:   tcyc_q   <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      st_q       <= st_d;
      active_q   <= active_d;
      relay_q    <= relay_d;
      cc_q       <= cc_d;
      fall_q     <= fall_d;
      rise_q     <= rise_d;
      high_q     <= high_d;
      ph_q       <= ph_d;
      pl_q       <= pl_d;
      sum_q      <= sum_d;
      gain_q     <= gain_d;
      md_start_q <= md_start_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kp_q     <= kp_d;
    ki_q     <= ki_d;
    amp_q    <= amp_d;
    tu_q     <= tu_d;
    sum_en_q <= sum_en_d;
    idx_q    <= idx_d;
    drv_q    <= drv_d;
    okp_q    <= okp_d;
    oki_q    <= oki_d;
    okd_q    <= okd_d;
    fin_q    <= fin_d;
  end

  assign in_stall_o   = (st_q != S_IDLE);
  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = ov_q;
  assign drive_o      = drv_q;
  assign prop_gain_o  = okp_q;
  assign integ_gain_o = oki_q;
  assign deriv_gain_o = okd_q;
  assign finished_o   = fin_q;

endmodule

>>> tb/sv/relay_pid_autotuner_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench of relay_pid_autotuner_unit: relay runs, gain math, config.
// Depends on rpa_pkg and the autotuner RTL; carries its own predictor of the tuner.
module relay_pid_autotuner_unit_test;
  import rpa_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;  // quiet cycles
  localparam int RANDOM_ITEMS   = 600;

  // ---------------------------------------------------------------- DUT ports
  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 mode_i = 1'b0;
  logic [SAMPLE_W-1:0]  sample_i = '0;
  logic [TIME_W-1:0]    time_us_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [15:0]          drive_o;
  logic [GAIN_W-1:0]    prop_gain_o, integ_gain_o, deriv_gain_o;
  logic                 finished_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;

  relay_pid_autotuner_unit i_dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------- tuner predictor
  typedef struct {
    logic [15:0]       drive;
    logic [GAIN_W-1:0] kp, ki, kd;
    logic              fin;
  } tuner_out_t;

  tuner_out_t expected_q[$];

  // shadow registers
  logic signed [15:0] sh_target, sh_drv_low, sh_drv_high;
  logic [1:0]         sh_rule;
  logic [23:0]        sh_interval;
  logic [7:0]         sh_cycles;
  // shadow tuner state
  bit                 tn_active, tn_relay;
  int unsigned        tn_cycle;
  logic [31:0]        tn_fall, tn_rise, tn_high, tn_low;
  longint             tn_peak_hi, tn_peak_lo;
  logic [63:0]        tn_sum [3];
  logic [31:0]        tn_gain[3];

  int  errors = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  cfg_writes = 0;
  int  rises_seen = 0;
  bit  no_idle = 1'b0;
  bit  in_held = 1'b0;

  function automatic logic [63:0] muldiv_floor(logic [63:0] x, logic [63:0] y,
                                               logic [63:0] den);
    logic [127:0] p;
    logic [127:0] q;
    p = {64'd0, x} * {64'd0, y};
    q = p / {64'd0, den};
    return (q[127:64] != 0) ? '1 : q[63:0];
  endfunction

  function automatic logic [31:0] clip32(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  task automatic model_reset();
    sh_target = 16'sd0; sh_drv_low = 16'sd0; sh_drv_high = 16'sd255;
    sh_rule = RULE_BASIC; sh_interval = 24'd1000; sh_cycles = 8'd10;
    tn_active = 0; tn_relay = 0; tn_cycle = 0;
    tn_fall = 0; tn_rise = 0; tn_high = 0; tn_low = 0;
    tn_peak_hi = -32768; tn_peak_lo = 32767;
    for (int k = 0; k < 3; k++) begin
      tn_sum[k] = 0; tn_gain[k] = 0;
    end
  endtask

  task automatic model_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] dat);
    case (idx)
      REG_TARGET:   sh_target   = dat[15:0];
      REG_DRV_LOW:  sh_drv_low  = dat[15:0];
      REG_DRV_HIGH: sh_drv_high = dat[15:0];
      REG_RULE:     sh_rule     = dat[1:0];
      REG_INTERVAL: sh_interval = dat;
      REG_CYCLES:   sh_cycles   = dat[7:0];
      default: ;  // unmapped index, ignored
    endcase
  endtask

  // Ziegler-Nichols gains on a relay rise
  task automatic zn_gains();
    longint      dd, aa;
    logic [63:0] d, a, l, tu, kpm, tdm;
    logic [31:0] kp, ki, kd;
    dd  = longint'(sh_drv_high) - longint'(sh_drv_low);
    aa  = tn_peak_hi - tn_peak_lo;
    d   = (dd > 0) ? 64'(dd) : 64'd0;
    a   = (aa > 0) ? 64'(aa) : 64'd1;
    l   = (sh_interval != 0) ? 64'(sh_interval) : 64'd1;
    tu  = {32'd0, tn_high} + {32'd0, tn_low};
    if (tu == 0) tu = 1;
    kpm = 64'(rule_kp_milli(sh_rule));
    tdm = 64'(rule_td_milli(sh_rule));
    kp  = clip32(muldiv_floor((kpm * d) << FRAC_BITS, 64'(FOUR_OVER_PI_Q30),
                              64'd1000 * a) >> 30);
    ki  = clip32(muldiv_floor({32'd0, kp}, 64'd2 * l, tu));
    kd  = clip32(muldiv_floor({32'd0, kp} * tdm, tu, 64'd1000 * l));
    tn_gain[0] = kp; tn_gain[1] = ki; tn_gain[2] = kd;
    if (tn_cycle > 1) begin
      for (int k = 0; k < 3; k++) begin
        tn_sum[k] = tn_sum[k] + {32'd0, tn_gain[k]};
        if (tn_sum[k] > 64'hFF_FFFF_FFFF) tn_sum[k] = 64'hFF_FFFF_FFFF;
      end
    end
    rises_seen++;
  endtask

  task automatic tuner_predict(bit m, logic [15:0] s_raw, logic [31:0] t);
    longint     s, tgt;
    int unsigned tc;
    tuner_out_t r;
    s   = longint'($signed(s_raw));
    tgt = longint'(sh_target);
    tc  = (sh_cycles < 3) ? 3 : 32'(sh_cycles);
    if (m) begin
      tn_active = 1; tn_relay = 1; tn_cycle = 0;
      tn_fall = t; tn_rise = t; tn_high = 0; tn_low = 0;
      tn_peak_hi = -32768; tn_peak_lo = 32767;
      for (int k = 0; k < 3; k++) tn_sum[k] = 0;
    end else if (tn_active) begin
      if (s > tn_peak_hi) tn_peak_hi = s;
      if (s < tn_peak_lo) tn_peak_lo = s;
      if (tn_relay && s > tgt) begin
        tn_relay = 0; tn_fall = t; tn_high = t - tn_rise; tn_peak_hi = tgt;
      end
      if (!tn_relay && s < tgt) begin
        tn_relay = 1; tn_rise = t; tn_low = t - tn_fall;
        zn_gains();
        tn_peak_lo = tgt;
        if (tn_cycle < 255) tn_cycle++;
      end
      if (tn_cycle >= tc) begin
        for (int k = 0; k < 3; k++) tn_gain[k] = clip32(tn_sum[k] / 64'(tn_cycle - 2));
        tn_relay = 0; tn_active = 0;
      end
    end
    r.drive = (tn_active && tn_relay) ? sh_drv_high : sh_drv_low;
    r.kp = tn_gain[0]; r.ki = tn_gain[1]; r.kd = tn_gain[2];
    r.fin = !tn_active && tn_cycle != 0;
    expected_q.push_back(r);
  endtask

  // ------------------------------------------------------- result checking
  always @(posedge clk_i) begin
    tuner_out_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: result with no item pending, drive %h", $time, drive_o);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (drive_o !== e.drive) begin
          $display("%0t: drive exp %h act %h", $time, e.drive, drive_o); errors++;
        end
        if (prop_gain_o !== e.kp) begin
          $display("%0t: prop_gain exp %h act %h", $time, e.kp, prop_gain_o); errors++;
        end
        if (integ_gain_o !== e.ki) begin
          $display("%0t: integ_gain exp %h act %h", $time, e.ki, integ_gain_o); errors++;
        end
        if (deriv_gain_o !== e.kd) begin
          $display("%0t: deriv_gain exp %h act %h", $time, e.kd, deriv_gain_o); errors++;
        end
        if (finished_o !== e.fin) begin
          $display("%0t: finished exp %b act %b", $time, e.fin, finished_o); errors++;
        end
      end
    end
  end

  // receiver back-pressure, off during the no-idle stretch
  always @(posedge clk_i) begin
    out_stall_i <= !no_idle && ($urandom_range(0, 99) < 21);
  end

  // watchdog on quiet cycles
  int quiet = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, nothing moved for %0d cycles", $time, quiet);
      $display("== FAIL ==");
      $finish;
    end
  end

  // ------------------------------------------------------------- stimulus
  task automatic release_input();
    if (in_held) begin
      in_valid_i <= 1'b0;
      in_held = 0;
    end
  endtask

  // one item transfer on the input channel
  task automatic send_item(bit m, logic [15:0] s, logic [31:0] t);
    in_valid_i <= 1'b1; in_held = 1;
    mode_i <= m; sample_i <= s; time_us_i <= t;
    do @(posedge clk_i); while (in_stall_o);
    tuner_predict(m, s, t);
    items_sent++;
    if (!no_idle && $urandom_range(0, 99) < 21) begin
      release_input();
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    release_input();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // register write, block idle; upper data bits are random junk for narrow regs
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
    logic [23:0] dat;
    drain();
    dat = 24'($urandom);
    case (idx)
      REG_TARGET, REG_DRV_LOW, REG_DRV_HIGH: dat[15:0] = val[15:0];
      REG_RULE:   dat[1:0] = val[1:0];
      REG_CYCLES: dat[7:0] = val[7:0];
      default:    dat = val;
    endcase
    cfg_valid_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= dat;
    do @(posedge clk_i); while (!cfg_ready_o);
    model_config(idx, dat);
    cfg_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] level_near(int base, int lo, int hi);
    int v;
    v = base + $urandom_range(0, hi - lo) + lo;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // well-formed relay run: start, then alternating phases around target
  task automatic tune_run(int halves, int tmax);
    logic [31:0] t;
    int          n, span, tgt;
    t = $urandom;
    send_item(1'b1, 16'($urandom), t);
    for (int h = 0; h < halves; h++) begin
      n    = $urandom_range(0, 2);
      span = ($urandom_range(0, 9) == 0) ? 32767 : $urandom_range(1, 3000);
      tgt  = sh_target;
      for (int k = 0; k <= n; k++) begin
        t += $urandom_range(0, tmax);
        if ($urandom_range(0, 99) < 6)
          send_item($urandom_range(0, 15) == 0, 16'($urandom), t);  // noise
        else if (h % 2 == 0)  // relay on: stay at or under, then cross above
          send_item(1'b0, (k < n) ? level_near(tgt, -span, 0) : level_near(tgt, 1, span), t);
        else                  // relay off: stay at or over, then drop below
          send_item(1'b0, (k < n) ? level_near(tgt, 0, span) : level_near(tgt, -span, -1), t);
      end
    end
  endtask

  task automatic test_reset_defaults();
    // idle samples change nothing; defaults show up on drive
    send_item(1'b0, 16'h7FFF, 32'hFFFF_FFFF);
    send_item(1'b0, 16'h8000, 32'h0000_0000);
    tune_run(24, 5000);  // run with the default REG_CYCLES value
    send_item(1'b0, 16'h1234, 32'h5555_AAAA);  // after finish
  endtask

  task automatic test_directed_extremes();
    // wrap of the timestamp, full-scale samples, equal-to-target, zero period
    send_item(1'b1, 16'h0000, 32'hFFFF_FFF0);
    send_item(1'b0, 16'h8000, 32'hFFFF_FFF8);
    send_item(1'b0, 16'h0000, 32'hFFFF_FFFC);
    send_item(1'b0, 16'h7FFF, 32'h0000_0010);
    send_item(1'b0, 16'h0000, 32'h0000_0020);
    send_item(1'b0, 16'h8000, 32'h0000_0040);
    send_item(1'b0, 16'h7FFF, 32'h0000_0040);  // zero-length phases
    send_item(1'b0, 16'h8000, 32'h0000_0040);
    send_item(1'b1, 16'h5A5A, 32'h0000_0041);  // restart mid-run
    // inverted drive range, zero loop interval, unused rule, short run
    write_reg(REG_DRV_LOW, 24'h00_7FFF);
    write_reg(REG_DRV_HIGH, 24'h00_8000);
    write_reg(REG_INTERVAL, 24'd0);
    write_reg(REG_RULE, 24'd3);
    write_reg(REG_CYCLES, 24'd0);
    tune_run(8, 100);
    write_reg(REG_DRV_LOW, 24'h00_8000);
    write_reg(REG_DRV_HIGH, 24'h00_7FFF);
    write_reg(REG_INTERVAL, 24'hFFFFFF);
    write_reg(REG_TARGET, 24'h00_7FFF);  // nothing can rise above it
    tune_run(4, 1000);
    write_reg(REG_TARGET, 24'h00_8000);
    tune_run(4, 1000);
    write_reg(3'd7, 24'hFFFFFF);  // unmapped index
    write_reg(REG_TARGET, 24'd0);
  endtask

  task automatic test_rules_and_intervals();
    // each rule, a few intervals; lower tuning_cycles mid-run
    for (int r = 0; r < 4; r++) begin
      write_reg(REG_RULE, 24'(r));
      write_reg(REG_INTERVAL, (r == 0) ? 24'd1 : 24'($urandom_range(1, 24'hFFFFFF)));
      write_reg(REG_CYCLES, 24'd3);
      tune_run(10, (r == 1) ? 0 : 2_000_000);
    end
    write_reg(REG_CYCLES, 24'd8);
    tune_run(8, 3000);
    write_reg(REG_CYCLES, 24'd3);  // lowered while the run is active
    send_item(1'b0, 16'h0000, 32'd1);
    write_reg(REG_CYCLES, 24'd255);  // longest run, few items per phase
    tune_run(520, 50);
  endtask

  task automatic test_random_runs();
    int start_items, run;
    logic [15:0] lo, hi;
    start_items = items_sent;
    run = 0;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      no_idle = (run >= 6 && run < 12);
      lo = ($urandom_range(0, 4) == 0) ? 16'h8000 : 16'($urandom);
      hi = ($urandom_range(0, 4) == 0) ? 16'h7FFF : 16'($urandom);
      write_reg(REG_DRV_LOW, {8'h00, lo});
      write_reg(REG_DRV_HIGH, {8'h00, hi});
      write_reg(REG_TARGET, ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                        : 24'($urandom_range(0, 4000) - 2000));
      write_reg(REG_RULE, 24'($urandom_range(0, 3)));
      write_reg(REG_INTERVAL, ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                          : 24'($urandom_range(0, 5000)));
      write_reg(REG_CYCLES, 24'($urandom_range(0, 9)));
      tune_run(2 * ((sh_cycles < 3 ? 3 : int'(sh_cycles)) + 1) + int'($urandom_range(0, 2)),
               ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom_range(0, 20000));
      if ($urandom_range(0, 4) == 0) begin  // raw noise burst
        repeat ($urandom_range(1, 10))
          send_item($urandom_range(0, 7) == 0, 16'($urandom), $urandom);
      end
      if (run % 7 == 3) drain();  // sender waits for every result
      run++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    model_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);
    test_reset_defaults();
    test_directed_extremes();
    test_rules_and_intervals();
    test_random_runs();
    drain();
    repeat (50) @(posedge clk_i);
    $display("Covered %0d item transfers, %0d results, %0d relay rises, %0d register writes.",
             items_sent, results_seen, rises_seen, cfg_writes);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/rpa_pkg.sv
hw/rtl/rpa_muldiv.sv
hw/rtl/relay_pid_autotuner_unit.sv
tb/sv/relay_pid_autotuner_unit_test.sv
